@@ rtl/bia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants for the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

   localparam int DEF_MAX_IDS = 256;
   localparam int BYTE_W      = 8;
   localparam int BIT_SEL_W   = 3;
   localparam int ID_W        = 8;
   localparam int CAP_W       = 9;
   localparam int COUNT_W     = 9;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
   localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

   // register index as seen in paddr bit 2
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef struct packed {
      logic                  full;
      logic [BIT_SEL_W-1:0]  low_bit;
      logic                  bit_set;
      logic [BYTE_W-1:0]     set_byte;
      logic [BYTE_W-1:0]     clr_byte;
   } byte_info_type;

endpackage

@@ rtl/bia_bitmap_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_bitmap_ram
// Byte-wide bitmap store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bia_bitmap_ram #(
   parameter int AW = 5
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic [bia_pkg::BYTE_W-1:0] wdata,
   input  logic [AW-1:0]             raddr,
   output logic [bia_pkg::BYTE_W-1:0] rdata
);
   import bia_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bia_byte_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_byte_unit
// Shared byte compare unit: fullness, lowest clear bit, bit test and the
// updated byte for a claim or a release.
// ----------------------------------------------------------------------------
module bia_byte_unit (
   input  logic [bia_pkg::BYTE_W-1:0]    data,
   input  logic [bia_pkg::BIT_SEL_W-1:0] bit_sel,
   output bia_pkg::byte_info_type        info
);
   import bia_pkg::*;

   logic [BIT_SEL_W-1:0] low;

   // scan from the top so the lowest clear bit wins
   always_comb begin
      low = '0;
      for (int j = BYTE_W - 1; j >= 0; j--) begin
         if (!data[j]) begin
            low = BIT_SEL_W'(j);
         end
      end
   end

   always_comb begin
      info.full     = (data == FULL_BYTE);
      info.low_bit  = low;
      info.bit_set  = data[bit_sel];
      info.set_byte = data | (BYTE_W'(1) << low);
      info.clr_byte = data & ~(BYTE_W'(1) << bit_sel);
   end

endmodule

@@ rtl/bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Lowest-free identifier allocator over a byte-wide bitmap store.
// ----------------------------------------------------------------------------
// flow: a free reads its bitmap byte, tests it in S_FREE_CHK and registers the
//   result strobe (an out-of-range free registers it straight from idle); allocate
//   reads one bitmap byte per cycle, at most active_capacity / 8 bytes.
// throughput: one word at a time; busy is high until the result is out.
// reset: a clearing pass writes zero to every byte of the store with busy high.
// an out-of-range free never raises busy, and the result side never stalls.
module bitmap_id_allocator #(
   parameter int MAX_IDS = bia_pkg::DEF_MAX_IDS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [bia_pkg::ID_W-1:0]      req_free_id,
   output logic                          rsp_strobe,
   output logic [bia_pkg::ID_W-1:0]      rsp_granted_id,
   output logic [1:0]                    rsp_status,
   output logic [bia_pkg::COUNT_W-1:0]   rsp_in_use_count,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bia_pkg::CSR_AW-1:0]    paddr,
   input  logic [bia_pkg::CSR_DW-1:0]    pwdata,
   output logic [bia_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);
   import bia_pkg::*;

   localparam int BYTES = MAX_IDS / 8;
   localparam int AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
   localparam int CNTW  = $clog2(MAX_IDS + 1);

   typedef enum logic [4:0] {
      S_CLEAR    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_SCAN     = 5'b00100,
      S_FREE_CHK = 5'b01000,
      S_SPARE    = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW:0]          scan_ff, scan_in;
   logic [AW-1:0]        chk_ff, chk_in;
   logic                 pend_ff, pend_in;
   logic [BIT_SEL_W-1:0] bit_ff, bit_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ID_W-1:0]      gid_ff, gid_in;
   status_type           stat_ff, stat_in;
   logic                 strobe_ff, strobe_in;

   logic [CNTW-1:0]      cap_lim;
   logic [CNTW-1:0]      cap_eff;
   logic [AW:0]          nbytes;
   logic                 id_range;
   logic                 csr_we;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [BYTE_W-1:0]    ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [BYTE_W-1:0]    ram_rdata;
   byte_info_type        info;

   bia_bitmap_ram #(
      .AW(AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bia_byte_unit u_byte (
      .data    (ram_rdata),
      .bit_sel (bit_ff),
      .info    (info)
   );

   // capacity clipped to the store and rounded down to whole bytes
   always_comb begin
      if (32'(cap_ff) > MAX_IDS) begin
         cap_lim = CNTW'(MAX_IDS);
      end else begin
         cap_lim = CNTW'(cap_ff);
      end
      cap_eff  = cap_lim & ~CNTW'(7);
      nbytes   = (AW+1)'(cap_eff >> 3);
      id_range = (32'(req_free_id) >= 32'(cap_eff));
   end

   assign csr_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
   assign cap_in = csr_we ? pwdata[CAP_W-1:0] : cap_ff;
   assign prdata = (paddr[2] == REG_CAPACITY) ? CSR_DW'(cap_ff) : '0;
   assign pready = 1'b1;

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      chk_in    = chk_ff;
      pend_in   = 1'b0;
      bit_in    = bit_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      gid_in    = gid_ff;
      stat_in   = stat_ff;
      strobe_in = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = chk_ff;
      ram_wdata = info.set_byte;
      ram_raddr = scan_ff[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[AW-1:0];
            ram_wdata = '0;
            scan_in   = scan_ff + 1'b1;
            if (&scan_ff[AW-1:0]) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ram_raddr = AW'(req_free_id[ID_W-1:BIT_SEL_W]);
            if (start) begin
               cmd_in = cmd_type'(req_command);
               if (cmd_type'(req_command) == CMD_ALLOC) begin
                  scan_in  = '0;
                  state_in = S_SCAN;
               end else if (id_range) begin
                  gid_in    = '0;
                  stat_in   = ST_RANGE;
                  strobe_in = 1'b1;
               end else begin
                  // byte read issued this cycle, tested next cycle
                  bit_in   = req_free_id[BIT_SEL_W-1:0];
                  chk_in   = AW'(req_free_id[ID_W-1:BIT_SEL_W]);
                  state_in = S_FREE_CHK;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && !info.full) begin
               ram_we    = 1'b1;
               ram_waddr = chk_ff;
               ram_wdata = info.set_byte;
               cnt_in    = cnt_ff + 1'b1;
               gid_in    = ID_W'({chk_ff, info.low_bit});
               stat_in   = ST_OK;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else if (scan_ff < nbytes) begin
               // read next byte while testing the previous one
               ram_raddr = scan_ff[AW-1:0];
               pend_in   = 1'b1;
               chk_in    = scan_ff[AW-1:0];
               scan_in   = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               gid_in    = '0;
               stat_in   = ST_FULL;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FREE_CHK: begin
            gid_in    = '0;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (!info.bit_set) begin
               stat_in = ST_NOT_ALLOC;
            end else begin
               stat_in   = ST_OK;
               ram_we    = 1'b1;
               ram_waddr = chk_ff;
               ram_wdata = info.clr_byte;
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         scan_ff   <= '0;
         pend_ff   <= 1'b0;
         cnt_ff    <= '0;
         cap_ff    <= CAP_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
         cap_ff    <= cap_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff  <= chk_in;
      bit_ff  <= bit_in;
      cmd_ff  <= cmd_in;
      gid_ff  <= gid_in;
      stat_ff <= stat_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_granted_id   = gid_ff;
   assign rsp_status       = stat_ff;
   assign rsp_in_use_count = COUNT_W'(cnt_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_IDS)
      else $error("in-use count above store size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (cmd_type'(req_command) == CMD_ALLOC)) |=> busy)
      else $error("allocate accepted without going busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(reset)) |-> ($past(busy) || $past(start)))
      else $error("result word without a command");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(reset) && (cmd_ff == CMD_ALLOC) && (stat_ff == ST_OK))
      |-> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("granted word did not bump the count");

endmodule

@@ tb/tb_bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_allocator
// Self-checking bench for the lowest-free identifier allocator: a queue-fed
// command driver, a result monitor checked against an in-bench bitmap model,
// and capacity register writes between phases over the csr port.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator;
   import bia_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      cmd_type         command;
      logic [ID_W-1:0] free_id;
      int              gap;
   } id_cmd_type;

   typedef struct {
      logic [ID_W-1:0]    granted_id;
      status_type         status;
      logic [COUNT_W-1:0] in_use_count;
   } id_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = 1'b0;
   logic [ID_W-1:0]     req_free_id = '0;
   logic                rsp_strobe;
   logic [ID_W-1:0]     rsp_granted_id;
   logic [1:0]          rsp_status;
   logic [COUNT_W-1:0]  rsp_in_use_count;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // bitmap model state
   bit [DEF_MAX_IDS-1:0] id_map = '0;
   logic [COUNT_W-1:0]   ids_in_use = '0;
   logic [CAP_W-1:0]     cap_setting = CAP_RESET;

   id_cmd_type    id_cmd_queue[$];
   id_result_type id_results_due[$];
   id_cmd_type    cur_cmd = '{CMD_ALLOC, '0, 0};
   bit         presenting = 1'b0;
   bit         no_gap_run = 1'b0;
   int         gap_count = 0;
   int         stall_cycles = 0;
   int         fail_cnt = 0;
   int         cmds_done = 0;
   int         cap_writes = 0;
   int         peak_in_use = 0;
   int         status_seen[4] = '{0, 0, 0, 0};

   bitmap_id_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_free_id      (req_free_id),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_status       (rsp_status),
      .rsp_in_use_count (rsp_in_use_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic id_result_type allocate_or_release(cmd_type cmd,
                                                         logic [ID_W-1:0] id);
      id_result_type r;
      int lim;
      r.granted_id = '0;
      r.status = ST_OK;
      lim = (int'(cap_setting) > DEF_MAX_IDS) ? DEF_MAX_IDS : int'(cap_setting);
      lim = lim - lim % BYTE_W;
      if (cmd == CMD_ALLOC) begin
         r.status = ST_FULL;
         // skipping full bytes lands on the same lowest clear bit
         for (int k = 0; k < lim; k++) begin
            if (!id_map[k]) begin
               id_map[k] = 1'b1;
               ids_in_use++;
               r.granted_id = ID_W'(k);
               r.status = ST_OK;
               break;
            end
         end
      end else if (int'(id) >= lim) begin
         r.status = ST_RANGE;
      end else if (!id_map[id]) begin
         r.status = ST_NOT_ALLOC;
      end else begin
         id_map[id] = 1'b0;
         if (ids_in_use != 0) ids_in_use--;
      end
      r.in_use_count = ids_in_use;
      return r;
   endfunction

   // mostly an id that is currently held, so frees actually release
   function automatic logic [ID_W-1:0] pick_release_id();
      int base;
      base = $urandom_range(0, DEF_MAX_IDS - 1);
      if ($urandom_range(0, 9) < 7) begin
         for (int k = 0; k < DEF_MAX_IDS; k++) begin
            if (id_map[(base + k) % DEF_MAX_IDS]) return ID_W'((base + k) % DEF_MAX_IDS);
         end
      end
      return ID_W'($urandom);
   endfunction

   task automatic queue_cmd(input cmd_type c, input logic [ID_W-1:0] id);
      int g;
      while (id_cmd_queue.size() >= 2) @(posedge clock);
      if ($urandom_range(0, 39) == 0) no_gap_run = !no_gap_run;
      g = no_gap_run ? 0 : $urandom_range(0, 10);
      id_cmd_queue.push_back('{c, id, g});
   endtask

   task automatic run_random(input int n, input int alloc_pct);
      cmd_type c;
      repeat (n) begin
         c = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
         queue_cmd(c, (c == CMD_ALLOC) ? ID_W'($urandom) : pick_release_id());
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (id_cmd_queue.size() != 0 || presenting || id_results_due.size() != 0 || busy)
         @(posedge clock);
   endtask

   // write the capacity register, then read it back
   task automatic set_capacity(input logic [CAP_W-1:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_CAPACITY, 2'b00};
      pwdata <= CSR_DW'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      cap_setting = val;
      cap_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[CAP_W-1:0] !== val) begin
         $error("active_capacity readback: expected %0d, actual %0d", val, prdata[CAP_W-1:0]);
         fail_cnt++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin : cmd_driver
      id_result_type due;
      if (reset) begin
         start <= 1'b0;
         req_command <= CMD_ALLOC;
         req_free_id <= '0;
         presenting = 1'b0;
         gap_count = 0;
      end else begin
         if (start && !busy) begin
            due = allocate_or_release(cur_cmd.command, cur_cmd.free_id);
            id_results_due.push_back(due);
            status_seen[due.status]++;
            if (int'(due.in_use_count) > peak_in_use) peak_in_use = due.in_use_count;
            cmds_done++;
            presenting = 1'b0;
         end
         if (!presenting && id_cmd_queue.size() != 0) begin
            if (gap_count < id_cmd_queue[0].gap) begin
               gap_count++;
            end else begin
               cur_cmd = id_cmd_queue.pop_front();
               presenting = 1'b1;
               gap_count = 0;
            end
         end
         start <= presenting;
         req_command <= cur_cmd.command;
         req_free_id <= cur_cmd.free_id;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      id_result_type want;
      if (!reset && rsp_strobe) begin
         if (id_results_due.size() == 0) begin
            $error("result word with nothing outstanding: id %0d status %0d count %0d",
                   rsp_granted_id, rsp_status, rsp_in_use_count);
            fail_cnt++;
         end else begin
            want = id_results_due.pop_front();
            if (rsp_granted_id !== want.granted_id) begin
               $error("granted_id: expected %0d, actual %0d", want.granted_id, rsp_granted_id);
               fail_cnt++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               fail_cnt++;
            end
            if (rsp_in_use_count !== want.in_use_count) begin
               $error("in_use_count: expected %0d, actual %0d",
                      want.in_use_count, rsp_in_use_count);
               fail_cnt++;
            end
         end
      end
      if ((start && !busy) || rsp_strobe) stall_cycles = 0;
      else stall_cycles++;
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      wait_idle();

      // full capacity from reset: grants, release, double release, high id never held
      queue_cmd(CMD_ALLOC, 8'hFF);
      queue_cmd(CMD_ALLOC, 8'h00);
      queue_cmd(CMD_ALLOC, 8'hA5);
      queue_cmd(CMD_FREE, 8'd1);
      queue_cmd(CMD_FREE, 8'd1);
      queue_cmd(CMD_ALLOC, 8'h5A);
      queue_cmd(CMD_FREE, 8'd255);
      wait_idle();

      // smallest capacity: fill it, then frees at and above the limit
      set_capacity(CAP_W'(8));
      repeat (6) queue_cmd(CMD_ALLOC, 8'h00);
      queue_cmd(CMD_FREE, 8'd8);
      queue_cmd(CMD_FREE, 8'd255);
      wait_idle();

      // zero capacity: held ids are hidden from both commands
      set_capacity(CAP_W'(0));
      queue_cmd(CMD_ALLOC, 8'h00);
      queue_cmd(CMD_FREE, 8'd0);
      wait_idle();

      // not a multiple of eight, rounds down to one byte
      set_capacity(CAP_W'(13));
      queue_cmd(CMD_ALLOC, 8'h00);
      queue_cmd(CMD_FREE, 8'd7);
      wait_idle();

      // above the store size, clamps to the whole store
      set_capacity(CAP_W'(300));
      queue_cmd(CMD_ALLOC, 8'h00);
      queue_cmd(CMD_FREE, 8'd200);
      wait_idle();

      set_capacity(CAP_W'(8));
      run_random(200, 50);
      wait_idle();

      // fill the whole store, then release ids with mostly frees
      set_capacity(CAP_W'(DEF_MAX_IDS));
      run_random(300, 95);
      run_random(200, 15);
      wait_idle();

      set_capacity(CAP_W'(8 * $urandom_range(2, 31)));
      run_random(300, 60);
      wait_idle();

      set_capacity(CAP_W'($urandom_range(0, 511)));
      run_random(200, 50);
      wait_idle();

      set_capacity(CAP_W'(DEF_MAX_IDS));
      run_random(200, 50);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d commands over %0d capacity writes, peak of %0d ids held",
               cmds_done, cap_writes, peak_in_use);
      $display("outcomes: %0d ok, %0d full, %0d out of range, %0d not allocated",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
               status_seen[ST_NOT_ALLOC]);
      if (fail_cnt == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ bitmap_id_allocator.f @@
rtl/bia_pkg.sv
rtl/bia_bitmap_ram.sv
rtl/bia_byte_unit.sv
rtl/bitmap_id_allocator.sv
tb/tb_bitmap_id_allocator.sv
